FILE: sv/ehpd_pkg.sv
// Shared types and constants for the earliest-hit pair delta histogrammer.
// No dependencies; every other file imports this package.
package ehpd_pkg;

  localparam logic [7:0] TIMING_DEVICE = 8'd200;
  localparam int MAP_LEN = 32;
  localparam int IN_W = 72;
  localparam int OUT_W = 280;

  // Electronics channel to detector channel.
  localparam logic [5:0] CHAN_MAP [MAP_LEN] = '{
    6'd22, 6'd20, 6'd18, 6'd16, 6'd24, 6'd26, 6'd28, 6'd30,
    6'd25, 6'd27, 6'd29, 6'd31, 6'd23, 6'd21, 6'd19, 6'd17,
    6'd9,  6'd11, 6'd13, 6'd15, 6'd7,  6'd5,  6'd3,  6'd1,
    6'd6,  6'd4,  6'd2,  6'd0,  6'd8,  6'd10, 6'd12, 6'd14
  };

  typedef enum logic [1:0] {
    MODE_HIT   = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_READ  = 2'd2
  } ehpd_mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIT_WR,
    ST_RD_PAIR,
    ST_RD_ADDR,
    ST_RD_MEM,
    ST_RD_DATA,
    ST_FR_TIME,
    ST_FR_BIN,
    ST_FR_HRD,
    ST_FR_HWR,
    ST_DONE
  } ehpd_state_t;

endpackage

FILE: sv/ehpd_time_ram.sv
// Earliest-time store: one write port, two registered read ports.
// Depends on nothing but the package.
module ehpd_time_ram
  import ehpd_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);

  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: sv/ehpd_hist_ram.sv
// Histogram store: single port, read data registered.
// Depends on nothing but the package.
module ehpd_hist_ram
  import ehpd_pkg::*;
#(
  parameter int DEPTH = 255936,
  parameter int AW    = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/ehpd_bin_calc.sv
// Maps a time difference to a histogram slot (0 underflow, NBINS+1 overflow).
// Depends on the package only.
module ehpd_bin_calc
  import ehpd_pkg::*;
#(
  parameter int NBINS = 256,
  parameter int BW    = 9
) (
  input  logic [31:0]   time_a,
  input  logic [31:0]   time_b,
  input  logic [4:0]    shift,
  output logic [BW-1:0] bin
);

  localparam int NBW = $clog2(NBINS + 1);
  localparam int XW  = NBW + 34;

  logic signed [32:0]   delta;
  logic        [XW-1:0] span;
  logic signed [XW-1:0] x;
  logic        [XW-1:0] q;
  logic        [5:0]    sh1;

  always_comb begin
    delta = $signed({1'b0, time_a}) - $signed({1'b0, time_b});
    span  = XW'(NBINS) << shift;
    // Offset by half the span so the histogram is centered on zero.
    x     = (XW'(delta) <<< 1) + $signed(span);
    sh1   = {1'b0, shift} + 6'd1;
    q     = $unsigned(x) >> sh1;
    if (x[XW-1]) begin
      bin = '0;
    end else if (q >= XW'(NBINS)) begin
      bin = BW'(NBINS + 1);
    end else begin
      bin = BW'(q) + BW'(1);
    end
  end

endmodule

FILE: sv/earliest_hit_pair_delta_histogram.sv
// Hit: ST_HIT_WR only if its channel was seen. Read: ST_RD_PAIR to ST_RD_DATA. Frame:
// ST_FR_TIME per slot (NUM_CHANNELS*(NUM_CHANNELS-1)), ST_FR_BIN/HRD/HWR per hit pair.
// Throughput: one word at a time; the single histogram port sets the pair walk rate.
// Reset: synchronous; afterwards a clearing pass writes every histogram entry, one per
// cycle (2*NPAIRS*(NBINS+2) entries, 255936 at the defaults), with in_tready held low.
// Uses ehpd_pkg, ehpd_time_ram, ehpd_hist_ram and ehpd_bin_calc.
module earliest_hit_pair_delta_histogram
  import ehpd_pkg::*;
#(
  parameter int NUM_CHANNELS = 32,
  parameter int NBINS        = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // device, fifo, pixel, column, hit_time, read_detector, read_first, read_second, read_bin
  input  logic [IN_W-1:0]  in_tdata,
  // mode
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // hit_accepted, read_valid, bin_count, frame_count, frames_seen_first,
  // frames_seen_second, fills_first, fills_second, zero pad
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [4:0]       cfg_data
);

  localparam int NC         = NUM_CHANNELS;
  localparam int NPAIRS     = (NC * (NC - 1)) / 2;
  localparam int NSLOTS     = NBINS + 2;
  localparam int HIST_DEPTH = 2 * NPAIRS * NSLOTS;
  localparam int HAW        = $clog2(HIST_DEPTH);
  localparam int CHW        = $clog2(NC);
  localparam int TAW        = CHW + 1;
  localparam int BW         = $clog2(NSLOTS);
  localparam int PW         = $clog2(2 * NPAIRS + 1);
  localparam int PRW        = 13;

  ehpd_state_t state_r, state_nxt;

  logic [4:0]      shift_r;
  logic [HAW-1:0]  clr_cnt_r;
  logic [1:0][NC-1:0] seen_r;

  logic [31:0]     time_r;
  logic            det_r;
  logic [CHW-1:0]  ch_r;
  logic            rdet_r;
  logic [4:0]      ra_r, rb_r;
  logic [8:0]      rbin_r;
  logic            res_acc_r, res_valid_r;
  logic [31:0]     count_r;
  logic [PRW-1:0]  prod_r;
  logic [PW-1:0]   pidx_r;

  logic            wd_r;
  logic [CHW-1:0]  wa_r, wb_r;
  logic [HAW-1:0]  base_r;
  logic [BW-1:0]   bin_r;

  logic [47:0]     frames_r, fwh0_r, fwh1_r, fill0_r, fill1_r;
  logic            out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;

  // Input word fields.
  logic [1:0]  mode_in;
  logic [7:0]  dev_in;
  logic [4:0]  fifo_in;
  logic [2:0]  pix_in;
  logic [3:0]  col_in;
  logic [31:0] tin;
  logic        rdet_in;
  logic [4:0]  ra_in, rb_in;
  logic [8:0]  rbin_in;

  logic [6:0]     ech;
  logic [5:0]     map_val;
  logic           hit_ok, rd_ok, hseen, hdet, acc;
  logic [CHW-1:0] hch;

  logic last_b, last_a, walk_end, pair_hit, out_free, walk_done, advance;

  logic           t_we;
  logic [TAW-1:0] t_waddr, t_raddr_a, t_raddr_b;
  logic [31:0]    t_wdata, t_rdata_a, t_rdata_b;

  logic           h_we;
  logic [HAW-1:0] h_addr;
  logic [31:0]    h_wdata, h_rdata;
  logic [BW-1:0]  bin_calc;

  assign mode_in = in_tuser;
  assign dev_in  = in_tdata[7:0];
  assign fifo_in = in_tdata[12:8];
  assign pix_in  = in_tdata[15:13];
  assign col_in  = in_tdata[19:16];
  assign tin     = in_tdata[51:20];
  assign rdet_in = in_tdata[52];
  assign ra_in   = in_tdata[57:53];
  assign rb_in   = in_tdata[62:58];
  assign rbin_in = in_tdata[71:63];

  assign ech     = 7'(pix_in) + {1'b0, col_in, 2'b00};
  assign map_val = CHAN_MAP[ech[4:0]];
  assign hdet    = fifo_in[2];
  assign hch     = CHW'(map_val);
  assign hit_ok  = (dev_in == TIMING_DEVICE) && (fifo_in <= 5'd7) && (ech < 7'd32)
                && (ech < 7'(NC)) && ({1'b0, map_val} < 7'(NC));
  assign hseen   = seen_r[hdet][hch];
  assign rd_ok   = (ra_in < rb_in) && (7'(rb_in) < 7'(NC))
                && (13'(rbin_in) <= 13'(NBINS + 1));

  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  // Pair walk order: detector, then first channel, then second channel.
  assign last_b   = (wb_r == CHW'(NC - 1));
  assign last_a   = (wa_r == CHW'(NC - 2));
  assign walk_end = last_b && last_a && wd_r;
  assign pair_hit = seen_r[wd_r][wa_r] && seen_r[wd_r][wb_r];
  assign advance  = ((state_r == ST_FR_TIME) && !pair_hit) || (state_r == ST_FR_HWR);
  assign walk_done = advance && walk_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == HAW'(HIST_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          unique case (mode_in)
            MODE_HIT:   state_nxt = (hit_ok && hseen) ? ST_HIT_WR : ST_DONE;
            MODE_FRAME: state_nxt = ST_FR_TIME;
            MODE_READ:  state_nxt = rd_ok ? ST_RD_PAIR : ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_HIT_WR:  state_nxt = ST_DONE;
      ST_RD_PAIR: state_nxt = ST_RD_ADDR;
      ST_RD_ADDR: state_nxt = ST_RD_MEM;
      ST_RD_MEM:  state_nxt = ST_RD_DATA;
      ST_RD_DATA: state_nxt = ST_DONE;
      ST_FR_TIME: begin
        if (pair_hit) state_nxt = ST_FR_BIN;
        else if (walk_end) state_nxt = ST_DONE;
      end
      ST_FR_BIN: state_nxt = ST_FR_HRD;
      ST_FR_HRD: state_nxt = ST_FR_HWR;
      ST_FR_HWR: state_nxt = walk_end ? ST_DONE : ST_FR_TIME;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Earliest-time store ports. A first hit on a channel is written at once; a
  // repeat hit reads the stored time and compares it in the following cycle.
  always_comb begin
    t_we      = 1'b0;
    t_waddr   = {hdet, hch};
    t_wdata   = tin;
    t_raddr_a = {wd_r, wa_r};
    t_raddr_b = {wd_r, wb_r};
    if (state_r == ST_IDLE) begin
      t_raddr_a = {hdet, hch};
      t_we      = acc && (mode_in == MODE_HIT) && hit_ok && !hseen;
    end else if (state_r == ST_HIT_WR) begin
      t_waddr = {det_r, ch_r};
      t_wdata = time_r;
      t_we    = (time_r < t_rdata_a);
    end
  end

  always_comb begin
    h_we    = 1'b0;
    h_wdata = (h_rdata == 32'hFFFF_FFFF) ? h_rdata : h_rdata + 32'd1;
    h_addr  = base_r + HAW'(bin_r);
    unique case (state_r)
      ST_CLEAR: begin
        h_we    = 1'b1;
        h_addr  = clr_cnt_r;
        h_wdata = '0;
      end
      ST_RD_MEM: h_addr = HAW'(pidx_r * NSLOTS) + HAW'(rbin_r);
      ST_FR_HWR: h_we = 1'b1;
      default: h_we = 1'b0;
    endcase
  end

  ehpd_time_ram #(.AW(TAW)) u_time_ram (
    .clk     (clk),
    .we      (t_we),
    .waddr   (t_waddr),
    .wdata   (t_wdata),
    .raddr_a (t_raddr_a),
    .raddr_b (t_raddr_b),
    .rdata_a (t_rdata_a),
    .rdata_b (t_rdata_b)
  );

  ehpd_hist_ram #(.DEPTH(HIST_DEPTH), .AW(HAW)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .addr  (h_addr),
    .wdata (h_wdata),
    .rdata (h_rdata)
  );

  ehpd_bin_calc #(.NBINS(NBINS), .BW(BW)) u_bin_calc (
    .time_a (t_rdata_a),
    .time_b (t_rdata_b),
    .shift  (shift_r),
    .bin    (bin_calc)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r      <= '0;
      clr_cnt_r    <= '0;
      seen_r       <= '0;
      frames_r     <= '0;
      fwh0_r       <= '0;
      fwh1_r       <= '0;
      fill0_r      <= '0;
      fill1_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) shift_r <= cfg_data;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + HAW'(1);
      if (acc && (mode_in == MODE_HIT) && hit_ok) seen_r[hdet][hch] <= 1'b1;
      if (acc && (mode_in == MODE_FRAME)) begin
        frames_r <= frames_r + 48'd1;
        if (|seen_r[0]) fwh0_r <= fwh0_r + 48'd1;
        if (|seen_r[1]) fwh1_r <= fwh1_r + 48'd1;
      end
      if (state_r == ST_FR_HWR) begin
        if (wd_r) fill1_r <= fill1_r + 48'd1;
        else fill0_r <= fill0_r + 48'd1;
      end
      if (walk_done) seen_r <= '0;
      if ((state_r == ST_DONE) && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      time_r      <= tin;
      det_r       <= hdet;
      ch_r        <= hch;
      rdet_r      <= rdet_in;
      ra_r        <= ra_in;
      rb_r        <= rb_in;
      rbin_r      <= rbin_in;
      res_acc_r   <= (mode_in == MODE_HIT) && hit_ok;
      res_valid_r <= (mode_in == MODE_READ) && rd_ok;
      count_r     <= '0;
      wd_r        <= 1'b0;
      wa_r        <= '0;
      wb_r        <= CHW'(1);
      base_r      <= '0;
    end
    if (advance && !walk_end) begin
      base_r <= base_r + HAW'(NSLOTS);
      if (last_b) begin
        if (last_a) begin
          wd_r <= 1'b1;
          wa_r <= '0;
          wb_r <= CHW'(1);
        end else begin
          wa_r <= wa_r + CHW'(1);
          wb_r <= wa_r + CHW'(2);
        end
      end else begin
        wb_r <= wb_r + CHW'(1);
      end
    end
    if (state_r == ST_FR_BIN) bin_r <= bin_calc;
    if (state_r == ST_RD_PAIR) prod_r <= PRW'(ra_r) * (PRW'(2 * NC - 1) - PRW'(ra_r));
    if (state_r == ST_RD_ADDR) begin
      pidx_r <= (rdet_r ? PW'(NPAIRS) : PW'(0)) + PW'(prod_r >> 1)
              + PW'(rb_r) - PW'(ra_r) - PW'(1);
    end
    if (state_r == ST_RD_DATA) count_r <= h_rdata;
    if ((state_r == ST_DONE) && out_free) begin
      out_tdata_r <= {6'd0, fill1_r, fill0_r, fwh1_r, fwh0_r, frames_r,
                      count_r, res_valid_r, res_acc_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: sv/ehpd_checker.sv
// Port-level checks for the pair delta histogrammer, bound to the top level.
// Depends on ehpd_pkg and earliest_hit_pair_delta_histogram.
module ehpd_checker
  import ehpd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A word held back by the sink must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // A result is never both an accepted hit and a valid read.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("hit and read flags both set");

  // Bin count is zero unless the read was valid.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> (out_tdata[33:2] == 32'd0))
    else $error("bin count set without a valid read");

  // Reset starts the clearing pass, which takes no words.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // Each word is worked on alone.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while one is in work");

endmodule

bind earliest_hit_pair_delta_histogram ehpd_checker u_ehpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
